// File: rtl/svefg_pkg.sv
// shared types and constants of the sample voice edge fade gain unit
package svefg_pkg;

  localparam int POS_W  = 22;
  localparam int SMP_W  = 16;
  localparam int EDGE_W = 11;
  localparam int GAIN_W = 17;
  localparam int TAIL_W = 20;
  localparam int CHAN_W = 2;
  localparam int CFG_W  = 22;
  localparam int IDX_W  = 3;

  localparam logic [POS_W-1:0]  MAX_FRAMES = 22'd2097152;
  localparam logic [POS_W-1:0]  POS_LIMIT  = 22'd4194303;
  localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'd65536;

  typedef enum logic [IDX_W-1:0] {
    REG_TOTAL = 3'd0,
    REG_EDGE  = 3'd1,
    REG_GAIN  = 3'd2,
    REG_CHAN  = 3'd3,
    REG_TAIL  = 3'd4,
    REG_MUTED = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0]  total;
    logic [EDGE_W-1:0] edge_len;
    logic [GAIN_W-1:0] gain;
    logic [CHAN_W-1:0] chan;
    logic [TAIL_W-1:0] tail;
    logic              muted;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic div_step;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// File: rtl/svefg_cfg.sv
// configuration register bank
module svefg_cfg import svefg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TOTAL: cfg_nxt.total    = cfg_data[POS_W-1:0];
        REG_EDGE:  cfg_nxt.edge_len = cfg_data[EDGE_W-1:0];
        REG_GAIN:  cfg_nxt.gain     = cfg_data[GAIN_W-1:0];
        REG_CHAN:  cfg_nxt.chan     = cfg_data[CHAN_W-1:0];
        REG_TAIL:  cfg_nxt.tail     = cfg_data[TAIL_W-1:0];
        REG_MUTED: cfg_nxt.muted    = cfg_data[0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.total    <= POS_W'(1);
      cfg_r.edge_len <= EDGE_W'(1);
      cfg_r.gain     <= '0;
      cfg_r.chan     <= CHAN_W'(1);
      cfg_r.tail     <= '0;
      cfg_r.muted    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/svefg_ctrl.sv
// sequencer for one frame: accept, two multiply steps, divide, write
module svefg_ctrl import svefg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL1  = 5'b00010,
    ST_MUL2  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_WRITE = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // four quotient bits per cycle
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 2'd1;
        if (cnt_r == 2'd3) state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (stat.out_free) begin
          cmd.write = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

endmodule

// File: rtl/svefg_dp.sv
// datapath: position state, fade count, gain and fade products, divider, output register
module svefg_dp import svefg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic [SMP_W-1:0] smp_left,
  input  logic [SMP_W-1:0] smp_right,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [SMP_W-1:0] res_left,
  output logic [SMP_W-1:0] res_right,
  output logic             res_done
);

  typedef struct packed {
    logic [EDGE_W-1:0] rem;
    logic [SMP_W-1:0]  dq;
  } div_t;

  // restoring division, four steps; remainder stays below the divisor
  function automatic div_t div4(logic [EDGE_W-1:0] rem, logic [SMP_W-1:0] dq,
                                logic [EDGE_W-1:0] dv);
    logic [EDGE_W:0]   t;
    logic [EDGE_W-1:0] r;
    logic [SMP_W-1:0]  q;
    div_t              res;
    r = rem;
    q = dq;
    for (int i = 0; i < 4; i++) begin
      t = {r, q[SMP_W-1]};
      q = {q[SMP_W-2:0], 1'b0};
      if (t >= {1'b0, dv}) begin
        r    = EDGE_W'(t - {1'b0, dv});
        q[0] = 1'b1;
      end else begin
        r = t[EDGE_W-1:0];
      end
    end
    res.rem = r;
    res.dq  = q;
    return res;
  endfunction

  // voice state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             fin_r, fin_nxt;

  // per-frame registers
  logic [SMP_W-1:0]  sl_r, sr_r;
  logic              active_r, stereo_r;
  logic [EDGE_W-1:0] n_r, edge_r;
  logic [31:0]       pl_r, pr_r;
  logic [EDGE_W-1:0] reml_r, remr_r;
  logic [SMP_W-1:0]  dql_r, dqr_r;

  // output register
  logic             ov_r;
  logic [SMP_W-1:0] ol_r, or_r;
  logic             od_r;

  logic [POS_W-1:0]  total_c, pos_inc, rest, n1;
  logic [EDGE_W-1:0] edge_c, n_c;
  logic [POS_W:0]    end_pos;
  logic              active_c;

  always_comb begin
    total_c  = (cfg.total > MAX_FRAMES) ? MAX_FRAMES : cfg.total;
    edge_c   = (cfg.edge_len == '0) ? EDGE_W'(1) : cfg.edge_len;
    active_c = !fin_r && (pos_r < total_c) && !cfg.muted;
    pos_inc  = pos_r + POS_W'(1);
    rest     = total_c - pos_r;
    n1       = (rest < pos_inc) ? rest : pos_inc;
    n_c      = (n1 > {{(POS_W-EDGE_W){1'b0}}, edge_c}) ? edge_c : n1[EDGE_W-1:0];
    end_pos  = {1'b0, total_c} + {{(POS_W+1-TAIL_W){1'b0}}, cfg.tail};
    pos_nxt  = pos_r;
    fin_nxt  = fin_r;
    if (!fin_r) begin
      if (pos_r != POS_LIMIT) pos_nxt = pos_inc;
      // saturated position still counts against the end
      fin_nxt = ({1'b0, pos_nxt} >= end_pos);
    end
  end

  // magnitudes and clamped gain
  logic [SMP_W:0]    ml, mr;
  logic [GAIN_W-1:0] g_c;
  logic [33:0]       prodl, prodr;

  assign ml    = sl_r[SMP_W-1] ? (17'h10000 - {1'b0, sl_r}) : {1'b0, sl_r};
  assign mr    = sr_r[SMP_W-1] ? (17'h10000 - {1'b0, sr_r}) : {1'b0, sr_r};
  assign g_c   = (cfg.gain > UNITY_GAIN) ? UNITY_GAIN : cfg.gain;
  assign prodl = 34'(ml) * 34'(g_c);
  assign prodr = 34'(mr) * 34'(g_c);

  // fade product plus half the divisor, pre-shifted by 16
  logic [42:0] xl, xr;

  assign xl = 43'(pl_r) * 43'(n_r) + 43'({edge_r, 15'b0});
  assign xr = 43'(pr_r) * 43'(n_r) + 43'({edge_r, 15'b0});

  div_t dl, dr;

  assign dl = div4(reml_r, dql_r, edge_r);
  assign dr = div4(remr_r, dqr_r, edge_r);

  // sign and saturation
  function automatic logic [SMP_W-1:0] finish(logic neg, logic [SMP_W-1:0] q);
    logic [SMP_W-1:0] v;
    if (neg) begin
      v = (q > 16'd32768) ? 16'h8000 : SMP_W'(17'h10000 - {1'b0, q});
    end else begin
      v = (q > 16'd32767) ? 16'h7fff : q;
    end
    return v;
  endfunction

  logic [SMP_W-1:0] fl, fr, wl, wr;

  assign fl = finish(sl_r[SMP_W-1], dql_r);
  assign fr = finish(sr_r[SMP_W-1], dqr_r);
  assign wl = active_r ? fl : '0;
  assign wr = !active_r ? '0 : (stereo_r ? fr : fl);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      fin_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        pos_r <= pos_nxt;
        fin_r <= fin_nxt;
      end
      if (cmd.write) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sl_r     <= smp_left;
      sr_r     <= smp_right;
      active_r <= active_c;
      stereo_r <= cfg.chan[1];
      n_r      <= n_c;
      edge_r   <= edge_c;
    end
    if (cmd.mul1) begin
      pl_r <= prodl[31:0];
      pr_r <= prodr[31:0];
    end
    if (cmd.mul2) begin
      reml_r <= xl[42:32];
      dql_r  <= xl[31:16];
      remr_r <= xr[42:32];
      dqr_r  <= xr[31:16];
    end
    if (cmd.div_step) begin
      reml_r <= dl.rem;
      dql_r  <= dl.dq;
      remr_r <= dr.rem;
      dqr_r  <= dr.dq;
    end
    if (cmd.write) begin
      ol_r <= wl;
      or_r <= wr;
      od_r <= fin_r;
    end
  end

  assign stat.out_free = !ov_r || out_ready;
  assign out_valid     = ov_r;
  assign res_left      = ol_r;
  assign res_right     = or_r;
  assign res_done      = od_r;

endmodule

// File: rtl/sample_voice_edge_fade_gain_unit.sv
// top level of the sample voice edge fade gain unit
//
//  channel  dir  handshake          payload
//  in_      in   in_tvalid/tready   in_tdata: sample_left, sample_right
//  out_     out  out_tvalid/tready  out_tdata: out_left, out_right; out_tuser: done_res
//  cfg_     in   cfg_we             cfg_index, cfg_data
//
// each request runs through accept, gain multiply, fade multiply, divider steps of four
// quotient bits each (16-bit quotient by the edge length), and output write.
// the output register holds one result, so the next request is taken while it waits;
// the write step stalls only while a previous result is still untaken.
// reset is synchronous active low; it clears position, finished flag and output valid flag.
module sample_voice_edge_fade_gain_unit import svefg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,   // [15:0] sample_left, [31:16] sample_right
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,  // [15:0] out_left, [31:16] out_right
  output logic             out_tuser,  // [0] done_res
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  logic [SMP_W-1:0] res_left, res_right;

  svefg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  svefg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  svefg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .smp_left  (in_tdata[15:0]),
    .smp_right (in_tdata[31:16]),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .res_left  (res_left),
    .res_right (res_right),
    .res_done  (out_tuser)
  );

  assign out_tdata = {res_right, res_left};

endmodule
